// File: hdl/ean8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ean8_pkg;

	localparam int POSITION_WIDTH_DEF = 16;

	localparam int MODULES_TOTAL = 67;
	localparam int GUARD_SIDE    = 3;
	localparam int GUARD_CENTRE  = 5;
	localparam int DIGIT_MODULES = 7;
	localparam int HALF_DIGITS   = 4;
	localparam int DIGITS_TOTAL  = 8;
	localparam int CENTRE_LO     = GUARD_SIDE + HALF_DIGITS * DIGIT_MODULES;
	localparam int CENTRE_HI     = CENTRE_LO + GUARD_CENTRE;
	localparam int END_LO        = MODULES_TOTAL - GUARD_SIDE;

	// Configuration register indexes.
	localparam logic CFG_MARGIN_PIXELS = 1'b0;
	localparam logic CFG_MODULE_WIDTH  = 1'b1;

	localparam logic [6:0] LEFT_CODES [10] = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
	};

	typedef struct packed {
		logic [3:0] digit;
		logic [2:0] digit_position;
		logic       matched;
		logic       last_digit;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] digit;
	} match_t;

	function automatic logic is_data_module(input logic [6:0] m);
		return ((m >= 7'(GUARD_SIDE)) && (m < 7'(CENTRE_LO))) ||
			((m >= 7'(CENTRE_HI)) && (m < 7'(END_LO)));
	endfunction

	// True on the seventh module of a digit group.
	function automatic logic is_digit_end(input logic [6:0] m);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < HALF_DIGITS; k++) begin
			if (m == 7'(GUARD_SIDE + DIGIT_MODULES * k + DIGIT_MODULES - 1))
				hit = 1'b1;
			if (m == 7'(CENTRE_HI + DIGIT_MODULES * k + DIGIT_MODULES - 1))
				hit = 1'b1;
		end
		return hit;
	endfunction

	// The right half uses the complement of the left-hand codes.
	function automatic match_t match_pattern(input logic [6:0] pat, input logic right_half);
		match_t r;
		logic [6:0] code;
		r = '0;
		for (int j = 9; j >= 0; j--) begin
			code = right_half ? ~LEFT_CODES[j] : LEFT_CODES[j];
			if (code == pat) begin
				r.ok    = 1'b1;
				r.digit = 4'(j);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/ean8_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module ean8_seq #(
	parameter int POSITION_WIDTH = ean8_pkg::POSITION_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             pixel,
	input  wire logic             row_start,
	input  wire logic [9:0]       margin_pixels,
	input  wire logic [5:0]       module_width,
	output ean8_pkg::res_t        res,
	output logic                  res_valid
);

	logic [POSITION_WIDTH-1:0] pixel_position_q, next_sample_q;
	logic [6:0]                module_index_q, pattern_q;
	logic [3:0]                digit_count_q;

	logic [POSITION_WIDTH-1:0] pp, nsp, width_ext;
	logic [6:0]                mi, pat, pat_shift;
	logic [3:0]                dc;
	logic                      sample, data, group_end;
	ean8_pkg::match_t          hit;

	always_comb begin
		// A row start clears the counters for the pixel that carries it.
		pp  = row_start ? '0 : pixel_position_q;
		nsp = row_start ? POSITION_WIDTH'(margin_pixels) : next_sample_q;
		mi  = row_start ? '0 : module_index_q;
		pat = row_start ? '0 : pattern_q;
		dc  = row_start ? '0 : digit_count_q;

		width_ext = (module_width == '0) ? POSITION_WIDTH'(1) : POSITION_WIDTH'(module_width);
		sample    = (mi < 7'(ean8_pkg::MODULES_TOTAL)) && (pp == nsp);
		data      = ean8_pkg::is_data_module(mi);
		group_end = ean8_pkg::is_digit_end(mi);
		pat_shift = {pat[5:0], pixel};
		hit       = ean8_pkg::match_pattern(pat_shift, dc[2]);

		res.digit          = hit.digit;
		res.digit_position = dc[2:0];
		res.matched        = hit.ok;
		res.last_digit     = (dc[2:0] == 3'(ean8_pkg::DIGITS_TOTAL - 1));
		res_valid          = step && sample && data && group_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_position_q <= '0;
			next_sample_q    <= '0;
			module_index_q   <= '0;
			pattern_q        <= '0;
			digit_count_q    <= '0;
		end else if (step) begin
			pixel_position_q <= pp + POSITION_WIDTH'(1);
			next_sample_q    <= nsp;
			module_index_q   <= mi;
			pattern_q        <= pat;
			digit_count_q    <= dc;
			if (sample) begin
				next_sample_q  <= nsp + width_ext;
				module_index_q <= mi + 7'd1;
				if (data) begin
					pattern_q <= group_end ? '0 : pat_shift;
					if (group_end)
						digit_count_q <= dc + 4'd1;
				end
			end
		end
	end

	property p_index_bounded;
		@(posedge clk) disable iff (!arst_n)
		module_index_q <= 7'(ean8_pkg::MODULES_TOTAL);
	endproperty
	assert property (p_index_bounded) else $error("module index ran past the end guard");

	property p_eight_digits;
		@(posedge clk) disable iff (!arst_n)
		digit_count_q <= 4'(ean8_pkg::DIGITS_TOTAL);
	endproperty
	assert property (p_eight_digits) else $error("more than eight digits in a row");

endmodule
`default_nettype wire

// File: hdl/ean8_out.sv
`timescale 1ns / 1ps
`default_nettype none
module ean8_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire ean8_pkg::res_t res,
	input  wire logic           take,
	output logic                valid,
	output ean8_pkg::res_t      res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (take)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign valid = valid_q;

	// A new result is loaded only when the register is empty or being drained.
	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || take);
	endproperty
	assert property (p_no_overwrite) else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: hdl/ean8_row_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Fields (lowest bit first)                        | Accepted when
// s       | tdata: pixel, 7 zero bits; tuser: row_start      | s_tvalid && s_tready
// m       | tdata: digit[3:0], digit_position[6:4], 0; tuser: | m_tvalid && m_tready
//         | matched; tlast: last_digit                       |
// cfg     | cfg_index: 0 margin_pixels, 1 module_width       | cfg_we
//
// One pixel per cycle is taken while s_tready is high; a result is presented
// on m once the pixel that completes its digit has been accepted into the
// input register, stepped through the row sequencer and its result written
// to the result register.
// Reset clears the row counters; margin_pixels resets to 0, module_width to 1.
// While a result waits with m_tready low, one more pixel is held in the
// input register and then s_tready drops.
module ean8_row_decoder_core #(
	parameter int POSITION_WIDTH = ean8_pkg::POSITION_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // pixel
	input  wire logic       s_tuser,   // row_start
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // digit, digit_position
	output logic            m_tuser,   // matched
	output logic            m_tlast,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [9:0] cfg_wdata
);

	logic [9:0] margin_q;
	logic [5:0] width_q;
	logic       valid_s1, pixel_s1, start_s1;
	logic       advance, step, res_valid;
	ean8_pkg::res_t res, res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
			width_q  <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				ean8_pkg::CFG_MARGIN_PIXELS: margin_q <= cfg_wdata;
				ean8_pkg::CFG_MODULE_WIDTH:  width_q  <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pixel_s1 <= s_tdata[0];
			start_s1 <= s_tuser;
		end
	end

	ean8_seq #(.POSITION_WIDTH(POSITION_WIDTH)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.pixel         (pixel_s1),
		.row_start     (start_s1),
		.margin_pixels (margin_q),
		.module_width  (width_q),
		.res           (res),
		.res_valid     (res_valid)
	);

	ean8_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.take   (m_tready),
		.valid  (m_tvalid),
		.res_q  (res_q)
	);

	assign m_tdata = {1'b0, res_q.digit_position, res_q.digit};
	assign m_tuser = res_q.matched;
	assign m_tlast = res_q.last_digit;

	property p_last_is_eighth;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[6:4] == 3'(ean8_pkg::DIGITS_TOTAL - 1));
	endproperty
	assert property (p_last_is_eighth) else $error("last flag on a digit other than the eighth");

	property p_unmatched_zero;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[3:0] == 4'd0);
	endproperty
	assert property (p_unmatched_zero) else $error("unmatched digit is not zero");

	property p_s1_holds;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pixel_s1) && $stable(start_s1));
	endproperty
	assert property (p_s1_holds) else $error("stalled pixel lost from input register");

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int POS_W        = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SCAN_PIXELS  = 850;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_CASES    = 9;

	localparam logic [6:0] LEFT_SET [10] = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
	};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	// One directed scan row: optional register writes, then the pixels of the row.
	typedef struct packed {
		logic [1:0]  wr;          // bit 0 writes margin, bit 1 writes width
		logic [9:0]  margin;
		logic [9:0]  width_word;
		logic        sop;
		logic [15:0] lead;        // pixels generated before the first module
		logic [7:0]  gw;          // pixels generated per module
		logic [31:0] digs;        // first digit in the top nibble
		logic [7:0]  bad;         // bit i replaces digit i by a pattern in no table
		logic [7:0]  cut;         // modules generated
		logic [7:0]  tail;
		logic        typed;
	} scan_case_t;

	localparam scan_case_t SCAN_CASES [NUM_CASES] = '{
		// No row start since reset: sampling begins at pixel 0 despite the margin.
		'{2'b01, 10'd9, 10'd0, 1'b0, 16'd0, 8'd1, 32'h01234567, 8'h00, 8'd67, 8'd3, 1'b1},
		'{2'b00, 10'd9, 10'd0, 1'b1, 16'd9, 8'd1, 32'h89012345, 8'h00, 8'd67, 8'd0, 1'b1},
		// Zero width in the low bits acts as width 1.
		'{2'b11, 10'd0, 10'h3C0, 1'b1, 16'd0, 8'd1, 32'h99990000, 8'h00, 8'd67, 8'd0, 1'b1},
		// A finished row without a new row start ignores the largest settings.
		'{2'b11, 10'd1023, 10'd63, 1'b0, 16'd0, 8'd1, 32'h76543210, 8'h00, 8'd67,
			8'd0, 1'b0},
		'{2'b11, 10'd0, 10'd2, 1'b1, 16'd0, 8'd2, 32'h31415926, 8'b1000_0001, 8'd67,
			8'd0, 1'b1},
		// Row cut short and restarted by the next row.
		'{2'b00, 10'd0, 10'd2, 1'b1, 16'd0, 8'd2, 32'h27182818, 8'h00, 8'd20, 8'd0, 1'b0},
		// Noise after the end guard is ignored.
		'{2'b11, 10'd3, 10'd1, 1'b1, 16'd3, 8'd1, 32'h55554444, 8'h00, 8'd67, 8'd20, 1'b1},
		'{2'b11, 10'd2, 10'd1, 1'b1, 16'd5, 8'd1, 32'h12121212, 8'h00, 8'd67, 8'd0, 1'b0},
		'{2'b10, 10'd2, 10'd1, 1'b1, 16'd2, 8'd1, 32'h98765432, 8'h00, 8'd67, 8'd0, 1'b1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;    // pixel
	logic       s_tuser = 1'b0;    // row_start
	logic       m_tvalid;
	logic       m_tready = 1'b1;
	logic [7:0] m_tdata;           // digit, digit_position
	logic       m_tuser;           // matched
	logic       m_tlast;           // last_digit
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [9:0] cfg_wdata = 10'd0;

	ean8_row_decoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Row decoder state as the design should hold it.
	logic [POS_W-1:0] row_pixel = '0;
	logic [POS_W-1:0] sample_at = '0;
	logic [6:0]       modules_seen = '0;
	logic [6:0]       shift_bits = '0;
	logic [3:0]       digits_out = '0;
	logic [9:0]       margin_reg = 10'd0;
	logic [5:0]       width_reg = 6'd1;

	ean8_pkg::res_t digit_q [$];
	bit             pix_q [$];
	bit             sop_q [$];
	bit             typed_row = 1'b0;
	idle_mode_e     idle_mode = IDLE_NONE;
	int             errors = 0;
	int             live_pixels = 0;
	int             cycles = 0;

	function automatic int code_index(input logic [6:0] pat, input bit right);
		logic [6:0] c;
		for (int j = 0; j < 10; j++) begin
			c = right ? ~LEFT_SET[j] : LEFT_SET[j];
			if (c == pat)
				return j;
		end
		return 10;
	endfunction

	// Digits 0-3 take the left set, 4-7 its complement.
	function automatic logic [55:0] code_word(input logic [31:0] digs, input logic [7:0] bad,
			input logic [55:0] junk);
		logic [55:0] w;
		logic [3:0]  d;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			d = digs[31-4*i -: 4];
			if (bad[i])
				w[55-7*i -: 7] = junk[7*i +: 7];
			else if (i < ean8_pkg::HALF_DIGITS)
				w[55-7*i -: 7] = LEFT_SET[d];
			else
				w[55-7*i -: 7] = ~LEFT_SET[d];
		end
		return w;
	endfunction

	function automatic logic [31:0] rand_digits();
		logic [31:0] v;
		for (int i = 0; i < 8; i++)
			v[4*i +: 4] = 4'($urandom_range(0, 9));
		return v;
	endfunction

	function automatic int sender_gap_pct();
		return (idle_mode == IDLE_SENDER) ? 84 : (idle_mode == IDLE_BOTH) ? 23 : 0;
	endfunction

	function automatic int receiver_stall_pct();
		return (idle_mode == IDLE_RECEIVER) ? 84 : (idle_mode == IDLE_BOTH) ? 23 : 0;
	endfunction

	function automatic int field_diff(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic decode_pixel(input bit pix, input bit start);
		ean8_pkg::res_t r;
		logic [5:0]     w;
		bit             data;
		int             d;
		int             pos;
		int             hit;
		if (start) begin
			row_pixel = '0;
			sample_at = POS_W'(margin_reg);
			modules_seen = '0;
			shift_bits = '0;
			digits_out = '0;
		end
		if (modules_seen < ean8_pkg::MODULES_TOTAL && row_pixel == sample_at) begin
			w = (width_reg == 6'd0) ? 6'd1 : width_reg;
			data = 1'b0;
			d = 0;
			if (modules_seen >= ean8_pkg::GUARD_SIDE && modules_seen < ean8_pkg::CENTRE_LO) begin
				data = 1'b1;
				d = int'(modules_seen) - ean8_pkg::GUARD_SIDE;
			end else if (modules_seen >= ean8_pkg::CENTRE_HI &&
					modules_seen < ean8_pkg::END_LO) begin
				data = 1'b1;
				d = int'(modules_seen) - ean8_pkg::GUARD_SIDE - ean8_pkg::GUARD_CENTRE;
			end
			if (data) begin
				shift_bits = {shift_bits[5:0], pix};
				if (d % ean8_pkg::DIGIT_MODULES == ean8_pkg::DIGIT_MODULES - 1) begin
					pos = int'(digits_out[2:0]);
					hit = code_index(shift_bits, pos >= ean8_pkg::HALF_DIGITS);
					r.digit = (hit < 10) ? 4'(hit) : 4'd0;
					r.digit_position = 3'(pos);
					r.matched = (hit < 10);
					r.last_digit = (pos == ean8_pkg::DIGITS_TOTAL - 1);
					if (!typed_row)
						digit_q.push_back(r);
					digits_out = digits_out + 4'd1;
					shift_bits = '0;
				end
			end
			modules_seen = modules_seen + 7'd1;
			sample_at = sample_at + POS_W'(w);
		end
		row_pixel = row_pixel + 1'b1;
	endtask

	// The idling phase follows the share of pixels sent so far.
	task automatic send_pixel(input bit pix, input bit start);
		idle_mode = idle_mode_e'((live_pixels >= SCAN_PIXELS) ? 3 :
			(live_pixels * 4) / SCAN_PIXELS);
		while ($urandom_range(0, 99) < sender_gap_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, pix};
		s_tuser <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		live_pixels++;
		decode_pixel(pix, start);
	endtask

	task automatic play_scan();
		for (int i = 0; i < pix_q.size(); i++)
			send_pixel(pix_q[i], sop_q[i]);
		pix_q.delete();
		sop_q.delete();
	endtask

	// Margin and the unsampled pixels of each module carry random values.
	task automatic build_scan(input bit sop, input int lead, input int gw,
			input logic [55:0] pats, input int cut, input int tail);
		logic [66:0] mods;
		mods = {3'b101, pats[55:28], 5'b01010, pats[27:0], 3'b101};
		for (int i = 0; i < lead; i++) begin
			sop_q.push_back(sop && pix_q.size() == 0);
			pix_q.push_back(1'($urandom_range(0, 1)));
		end
		for (int m = 0; m < cut; m++) begin
			for (int k = 0; k < gw; k++) begin
				sop_q.push_back(sop && pix_q.size() == 0);
				pix_q.push_back((k == 0) ? mods[66-m] : 1'($urandom_range(0, 1)));
			end
		end
		for (int i = 0; i < tail; i++) begin
			sop_q.push_back(sop && pix_q.size() == 0);
			pix_q.push_back(1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_for_digits();
		s_tvalid <= 1'b0;
		while (digit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [9:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ean8_pkg::CFG_MARGIN_PIXELS)
			margin_reg = val;
		else
			width_reg = val[5:0];
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		ean8_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digit_q.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, %s %0d %0d %0b %0b",
					$time, "actual digit/pos/matched/last", m_tdata[3:0], m_tdata[6:4],
					m_tuser, m_tlast);
				errors++;
			end else begin
				want = digit_q.pop_front();
				errors += field_diff("digit", want.digit, m_tdata[3:0]);
				errors += field_diff("digit_position", want.digit_position, m_tdata[6:4]);
				errors += field_diff("matched", want.matched, m_tuser);
				errors += field_diff("last_digit", want.last_digit, m_tlast);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		scan_case_t     c;
		ean8_pkg::res_t r;
		int             row_no;
		int             kind;
		int             lead;
		int             cut;
		int             wsel;
		int             m;
		int             w;
		int             n;
		logic [7:0]     bad;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ci = 0; ci < NUM_CASES; ci++) begin
			c = SCAN_CASES[ci];
			if (c.wr != 2'b00) begin
				wait_for_digits();
				if (c.wr[0])
					write_cfg(ean8_pkg::CFG_MARGIN_PIXELS, c.margin);
				if (c.wr[1])
					write_cfg(ean8_pkg::CFG_MODULE_WIDTH, c.width_word);
			end
			typed_row = c.typed;
			if (c.typed) begin
				for (int i = 0; i < ean8_pkg::DIGITS_TOTAL; i++) begin
					r.digit = c.bad[i] ? 4'd0 : c.digs[31-4*i -: 4];
					r.digit_position = 3'(i);
					r.matched = !c.bad[i];
					r.last_digit = (i == ean8_pkg::DIGITS_TOTAL - 1);
					digit_q.push_back(r);
				end
			end
			build_scan(c.sop, int'(c.lead), int'(c.gw), code_word(c.digs, c.bad, '0),
				int'(c.cut), int'(c.tail));
			play_scan();
			typed_row = 1'b0;
		end

		row_no = 0;
		while (live_pixels < SCAN_PIXELS) begin
			if (row_no == 0 || $urandom_range(0, 2) == 0) begin
				wait_for_digits();
				m = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
				wsel = $urandom_range(0, 11);
				w = (wsel == 0) ? 0 : (wsel == 1) ? $urandom_range(4, 6) : $urandom_range(1, 3);
				kind = $urandom_range(0, 2);
				if (kind != 1)
					write_cfg(ean8_pkg::CFG_MARGIN_PIXELS, 10'(m));
				if (kind != 0)
					write_cfg(ean8_pkg::CFG_MODULE_WIDTH, {4'($urandom), 6'(w)});
			end
			w = (width_reg == 6'd0) ? 1 : int'(width_reg);
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				lead = int'(margin_reg);
				if ($urandom_range(0, 9) == 0)
					lead = lead + $urandom_range(0, 4) - 2;
				if (lead < 0)
					lead = 0;
				bad = '0;
				for (int i = 0; i < 8; i++)
					bad[i] = ($urandom_range(0, 9) == 0);
				cut = (kind < 70) ? ean8_pkg::MODULES_TOTAL :
					$urandom_range(1, ean8_pkg::MODULES_TOTAL - 1);
				build_scan($urandom_range(0, 19) != 0, lead, w,
					code_word(rand_digits(), bad, {$urandom, $urandom}), cut,
					$urandom_range(0, 4));
			end else begin
				// Noise with stray row starts.
				n = $urandom_range(20, 90);
				for (int i = 0; i < n; i++) begin
					sop_q.push_back(i == 0 || $urandom_range(0, 15) == 0);
					pix_q.push_back(1'($urandom_range(0, 1)));
				end
			end
			play_scan();
			row_no++;
		end

		wait_for_digits();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
